// File: rtl/mme_pkg.sv
// Shared types, constants and helpers for the matrix multiply engine.
// No dependencies; every other file of the block refers to this package.
package mme_pkg;

  localparam int MAX_DIM_DEF = 8;
  localparam int CFG_W       = 4;
  localparam int DATA_W      = 32;
  localparam int POS_W       = 3;
  localparam int PROD_W      = 64;
  localparam int ACC_W       = 68;
  localparam int FRAC_W      = 16;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;

  localparam logic [1:0] CMD_LOAD_A = 2'd0;
  localparam logic [1:0] CMD_LOAD_B = 2'd1;
  localparam logic [1:0] CMD_START  = 2'd2;

  localparam logic [1:0] REG_A_ROWS = 2'd0;
  localparam logic [1:0] REG_INNER  = 2'd1;
  localparam logic [1:0] REG_B_COLS = 2'd2;

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(8);

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC_W - 1);

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  typedef struct packed {
    logic [1:0]               command;
    logic [POS_W-1:0]         row_index;
    logic [POS_W-1:0]         col_index;
    logic signed [DATA_W-1:0] element_value;
  } in_req_t;

  typedef struct packed {
    logic [POS_W-1:0]         out_row;
    logic [POS_W-1:0]         out_col;
    logic signed [DATA_W-1:0] out_value;
    logic                     last_element;
  } out_res_t;

  // travels alongside each product through the datapath
  typedef struct packed {
    logic             vld;
    logic             first;
    logic             last;
    logic             last_elem;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } mac_tag_t;

  // zero acts as one, anything above the store size is clamped
  function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v, input int maxd);
    if (v == '0) begin
      return CFG_W'(1);
    end
    if (int'(v) > maxd) begin
      return CFG_W'(maxd);
    end
    return v;
  endfunction

endpackage

// File: rtl/mme_store.sv
// Element stores for A and B: one write port shared by loads, one registered read each.
// Depends on mme_pkg.
module mme_store #(
  parameter  int MAX_DIM = mme_pkg::MAX_DIM_DEF,
  localparam int DEPTH   = MAX_DIM * MAX_DIM,
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                             clk,
  input  logic                             rd_en,
  input  logic                             wr_a,
  input  logic                             wr_b,
  input  logic [ADDR_W-1:0]                wr_addr,
  input  logic signed [mme_pkg::DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]                rd_addr_a,
  input  logic [ADDR_W-1:0]                rd_addr_b,
  output logic signed [mme_pkg::DATA_W-1:0] rd_a,
  output logic signed [mme_pkg::DATA_W-1:0] rd_b
);

  logic signed [mme_pkg::DATA_W-1:0] mem_a [DEPTH];
  logic signed [mme_pkg::DATA_W-1:0] mem_b [DEPTH];
  logic signed [mme_pkg::DATA_W-1:0] rd_a_r;
  logic signed [mme_pkg::DATA_W-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= mem_a[rd_addr_a];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_b_r <= mem_b[rd_addr_b];
    end
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

// File: rtl/mme_seq.sv
// Sequencer: walks i, j, k over the result and issues one store read pair per cycle while adv is high.
// Depends on mme_pkg.
module mme_seq #(
  parameter  int MAX_DIM = mme_pkg::MAX_DIM_DEF,
  localparam int DEPTH   = MAX_DIM * MAX_DIM,
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        start,
  input  logic [mme_pkg::CFG_W-1:0]   dim_m,
  input  logic [mme_pkg::CFG_W-1:0]   dim_n,
  input  logic [mme_pkg::CFG_W-1:0]   dim_p,
  output logic                        busy,
  output logic [ADDR_W-1:0]           a_addr,
  output logic [ADDR_W-1:0]           b_addr,
  output mme_pkg::mac_tag_t           tag
);

  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int EXT_W  = ADDR_W + IDX_W + 1;

  mme_pkg::seq_state_t state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [IDX_W-1:0] lim_m_r, lim_m_nxt, lim_n_r, lim_n_nxt, lim_p_r, lim_p_nxt;
  logic             k_end, j_end, i_end, issue;

  assign k_end = (k_r == lim_n_r);
  assign j_end = (j_r == lim_p_r);
  assign i_end = (i_r == lim_m_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mme_pkg::SEQ_IDLE: begin
        if (start) begin
          state_nxt = mme_pkg::SEQ_RUN;
        end
      end
      mme_pkg::SEQ_RUN: begin
        if (adv && k_end && j_end && i_end) begin
          state_nxt = mme_pkg::SEQ_IDLE;
        end
      end
      default: state_nxt = mme_pkg::SEQ_IDLE;
    endcase
  end

  always_comb begin
    busy  = 1'b0;
    issue = 1'b0;
    case (state_r)
      mme_pkg::SEQ_IDLE: begin
        busy  = 1'b0;
        issue = 1'b0;
      end
      mme_pkg::SEQ_RUN: begin
        busy  = 1'b1;
        issue = adv;
      end
      default: begin
        busy  = 1'b0;
        issue = 1'b0;
      end
    endcase
  end

  always_comb begin
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    lim_m_nxt = lim_m_r;
    lim_n_nxt = lim_n_r;
    lim_p_nxt = lim_p_r;
    if (start && (state_r == mme_pkg::SEQ_IDLE)) begin
      i_nxt     = '0;
      j_nxt     = '0;
      k_nxt     = '0;
      lim_m_nxt = IDX_W'(dim_m - mme_pkg::CFG_W'(1));
      lim_n_nxt = IDX_W'(dim_n - mme_pkg::CFG_W'(1));
      lim_p_nxt = IDX_W'(dim_p - mme_pkg::CFG_W'(1));
    end else if (issue) begin
      if (!k_end) begin
        k_nxt = k_r + IDX_W'(1);
      end else begin
        k_nxt = '0;
        if (!j_end) begin
          j_nxt = j_r + IDX_W'(1);
        end else begin
          j_nxt = '0;
          i_nxt = i_r + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mme_pkg::SEQ_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      lim_m_r <= '0;
      lim_n_r <= '0;
      lim_p_r <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      lim_m_r <= lim_m_nxt;
      lim_n_r <= lim_n_nxt;
      lim_p_r <= lim_p_nxt;
    end
  end

  assign a_addr = ADDR_W'(EXT_W'(i_r) * EXT_W'(MAX_DIM) + EXT_W'(k_r));
  assign b_addr = ADDR_W'(EXT_W'(k_r) * EXT_W'(MAX_DIM) + EXT_W'(j_r));

  always_comb begin
    tag.vld       = issue;
    tag.first     = (k_r == '0);
    tag.last      = k_end;
    tag.last_elem = k_end && j_end && i_end;
    tag.row       = mme_pkg::POS_W'(i_r);
    tag.col       = mme_pkg::POS_W'(j_r);
  end

endmodule

// File: rtl/mme_mac.sv
// Datapath: multiply, exact accumulate, round to Q16.16 with saturation, output register.
// Depends on mme_pkg; fed by mme_store read data and the mme_seq tag.
module mme_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mme_pkg::mac_tag_t                 tag_in,
  input  logic signed [mme_pkg::DATA_W-1:0] a_data,
  input  logic signed [mme_pkg::DATA_W-1:0] b_data,
  input  logic                              out_stall,
  output logic                              adv,
  output logic                              out_valid,
  output mme_pkg::out_res_t                 out_data
);

  localparam int QW = mme_pkg::ACC_W - mme_pkg::FRAC_W;

  mme_pkg::mac_tag_t tag1_r, tag2_r, tag3_r;
  logic signed [mme_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic signed [mme_pkg::ACC_W-1:0]  acc_r, acc_nxt, rnd;
  logic signed [QW-1:0]              q;
  logic [QW-mme_pkg::DATA_W:0]       q_hi;
  logic signed [mme_pkg::DATA_W-1:0] sat_val;
  logic                              out_valid_r;
  mme_pkg::out_res_t                 out_data_r;

  assign adv = !(out_valid_r && out_stall);

  assign prod_nxt = mme_pkg::PROD_W'(a_data) * mme_pkg::PROD_W'(b_data);

  always_comb begin
    acc_nxt = acc_r;
    if (tag2_r.vld) begin
      acc_nxt = (tag2_r.first ? '0 : acc_r) + mme_pkg::ACC_W'(prod_r);
    end
  end

  // round half up, then clamp to 32 bits
  assign rnd  = acc_r + mme_pkg::RND_HALF;
  assign q    = QW'(rnd >>> mme_pkg::FRAC_W);
  assign q_hi = q[QW-1:mme_pkg::DATA_W-1];

  always_comb begin
    if ((&q_hi) || !(|q_hi)) begin
      sat_val = q[mme_pkg::DATA_W-1:0];
    end else if (q[QW-1]) begin
      sat_val = {1'b1, {(mme_pkg::DATA_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(mme_pkg::DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r      <= '0;
      tag2_r      <= '0;
      tag3_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      tag1_r      <= tag_in;
      tag2_r      <= tag1_r;
      tag3_r      <= tag2_r;
      out_valid_r <= tag3_r.vld && tag3_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
      acc_r  <= acc_nxt;
      if (tag3_r.vld && tag3_r.last) begin
        out_data_r.out_row      <= tag3_r.row;
        out_data_r.out_col      <= tag3_r.col;
        out_data_r.out_value    <= sat_val;
        out_data_r.last_element <= tag3_r.last_elem;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/matrix_multiply_engine.sv
// Matrix multiply engine top level: request channels, configuration registers, assertions.
// Depends on mme_pkg, mme_store, mme_seq and mme_mac.
//
// Load requests write one element of A or B per cycle while in_stall is low. A start
// request holds off further requests while the sequencer issues, for each of the clamped
// a_rows * inner_size * b_cols products, one read of each store and one multiply-accumulate,
// one per cycle while the datapath advances; the single multiplier and the one read port of
// each store set that rate. Results leave row-major through the read, product, accumulator and
// output registers; an output stall while out_valid is high freezes the whole datapath.
// Store entries hold no reset value and must be loaded before they are used.
module matrix_multiply_engine #(
  parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  mme_pkg::in_req_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output mme_pkg::out_res_t                  out_data,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mme_pkg::PADDR_W-1:0]        paddr,
  input  logic [mme_pkg::PDATA_W-1:0]        pwdata,
  output logic [mme_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LD_W   = ADDR_W + mme_pkg::POS_W + 1;
  localparam int CHK_W  = mme_pkg::POS_W + 6;

  logic [mme_pkg::CFG_W-1:0] a_rows_r, inner_size_r, b_cols_r;
  logic [1:0]                reg_idx;
  logic                      cfg_wr;
  logic                      req_ok, start, in_range, wr_a, wr_b;
  logic [ADDR_W-1:0]         wr_addr, a_addr, b_addr;
  logic                      adv, busy;
  mme_pkg::mac_tag_t         tag;
  logic signed [mme_pkg::DATA_W-1:0] rd_a, rd_b;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r     <= mme_pkg::DIM_RESET;
      inner_size_r <= mme_pkg::DIM_RESET;
      b_cols_r     <= mme_pkg::DIM_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        mme_pkg::REG_A_ROWS: a_rows_r     <= pwdata[mme_pkg::CFG_W-1:0];
        mme_pkg::REG_INNER:  inner_size_r <= pwdata[mme_pkg::CFG_W-1:0];
        mme_pkg::REG_B_COLS: b_cols_r     <= pwdata[mme_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mme_pkg::REG_A_ROWS: prdata = mme_pkg::PDATA_W'(a_rows_r);
      mme_pkg::REG_INNER:  prdata = mme_pkg::PDATA_W'(inner_size_r);
      mme_pkg::REG_B_COLS: prdata = mme_pkg::PDATA_W'(b_cols_r);
      default:             prdata = '0;
    endcase
  end

  // requests; loads are only taken while no start is reading the stores
  assign in_stall = busy;
  assign req_ok   = in_valid && !in_stall;
  assign start    = req_ok && (in_data.command == mme_pkg::CMD_START);
  assign in_range = (CHK_W'(in_data.row_index) < CHK_W'(MAX_DIM)) &&
                    (CHK_W'(in_data.col_index) < CHK_W'(MAX_DIM));
  assign wr_a     = req_ok && in_range && (in_data.command == mme_pkg::CMD_LOAD_A);
  assign wr_b     = req_ok && in_range && (in_data.command == mme_pkg::CMD_LOAD_B);
  assign wr_addr  = ADDR_W'(LD_W'(in_data.row_index) * LD_W'(MAX_DIM) +
                            LD_W'(in_data.col_index));

  mme_store #(.MAX_DIM(MAX_DIM)) u_store (
    .clk       (clk),
    .rd_en     (adv),
    .wr_a      (wr_a),
    .wr_b      (wr_b),
    .wr_addr   (wr_addr),
    .wr_data   (in_data.element_value),
    .rd_addr_a (a_addr),
    .rd_addr_b (b_addr),
    .rd_a      (rd_a),
    .rd_b      (rd_b)
  );

  mme_seq #(.MAX_DIM(MAX_DIM)) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .start  (start),
    .dim_m  (mme_pkg::eff_dim(a_rows_r, MAX_DIM)),
    .dim_n  (mme_pkg::eff_dim(inner_size_r, MAX_DIM)),
    .dim_p  (mme_pkg::eff_dim(b_cols_r, MAX_DIM)),
    .busy   (busy),
    .a_addr (a_addr),
    .b_addr (b_addr),
    .tag    (tag)
  );

  mme_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag_in    (tag),
    .a_data    (rd_a),
    .b_data    (rd_b),
    .out_stall (out_stall),
    .adv       (adv),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> in_stall)
    else $error("start request did not launch the sequencer");

  a_finish_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(in_stall) |-> $past(adv))
    else $error("sequencer finished on a frozen cycle");

  a_no_store_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_a || wr_b) |=> !tag.vld || $past(start) == 1'b0)
    else $error("store written while a read sweep starts");

endmodule

// File: tb/mme_checker.sv
// Result checker for the matrix multiply engine: watches the request, result and
// configuration ports, predicts each product matrix and compares it element by element.
// Depends on mme_pkg for the request and result structs and the command codes.
module mme_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  mme_pkg::in_req_t             in_data,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  mme_pkg::out_res_t            out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [mme_pkg::PADDR_W-1:0]  paddr,
  input  logic [mme_pkg::PDATA_W-1:0]  pwdata,
  output int                           mismatch_count,
  output int                           outstanding
);

  localparam int DIM = mme_pkg::MAX_DIM_DEF;
  localparam logic signed [71:0] SAT_HI = 72'sd2147483647;
  localparam logic signed [71:0] SAT_LO = -72'sd2147483648;

  logic signed [mme_pkg::DATA_W-1:0] a_store [DIM*DIM];
  logic signed [mme_pkg::DATA_W-1:0] b_store [DIM*DIM];
  logic [mme_pkg::CFG_W-1:0]         rows_cfg = mme_pkg::DIM_RESET;
  logic [mme_pkg::CFG_W-1:0]         inner_cfg = mme_pkg::DIM_RESET;
  logic [mme_pkg::CFG_W-1:0]         cols_cfg = mme_pkg::DIM_RESET;
  mme_pkg::out_res_t                 product_elements [$];
  int                                errors = 0;

  function automatic int clamp_dim(logic [mme_pkg::CFG_W-1:0] v);
    if (v == '0) begin
      return 1;
    end
    if (int'(v) > DIM) begin
      return DIM;
    end
    return int'(v);
  endfunction

  // exact sum of Q32.32 products, rounded half up to Q16.16, then saturated
  function automatic logic signed [mme_pkg::DATA_W-1:0] dot_q16(int r, int c, int n);
    logic signed [71:0] acc;
    longint             prod;
    acc = '0;
    for (int k = 0; k < n; k++) begin
      prod = longint'(a_store[r*DIM+k]) * longint'(b_store[k*DIM+c]);
      acc = acc + 72'(prod);
    end
    acc = (acc + 72'sd32768) >>> mme_pkg::FRAC_W;
    if (acc > SAT_HI) begin
      return 32'h7FFF_FFFF;
    end
    if (acc < SAT_LO) begin
      return 32'h8000_0000;
    end
    return acc[mme_pkg::DATA_W-1:0];
  endfunction

  task automatic queue_product_matrix();
    int                m;
    int                n;
    int                p;
    mme_pkg::out_res_t elem;
    m = clamp_dim(rows_cfg);
    n = clamp_dim(inner_cfg);
    p = clamp_dim(cols_cfg);
    for (int i = 0; i < m; i++) begin
      for (int j = 0; j < p; j++) begin
        elem.out_row      = mme_pkg::POS_W'(i);
        elem.out_col      = mme_pkg::POS_W'(j);
        elem.out_value    = dot_q16(i, j, n);
        elem.last_element = (i == m - 1) && (j == p - 1);
        product_elements.push_back(elem);
      end
    end
  endtask

  always @(posedge clk) begin
    mme_pkg::out_res_t want;
    if (!rst_n) begin
      rows_cfg  = mme_pkg::DIM_RESET;
      inner_cfg = mme_pkg::DIM_RESET;
      cols_cfg  = mme_pkg::DIM_RESET;
      product_elements.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          mme_pkg::REG_A_ROWS: rows_cfg = pwdata[mme_pkg::CFG_W-1:0];
          mme_pkg::REG_INNER:  inner_cfg = pwdata[mme_pkg::CFG_W-1:0];
          mme_pkg::REG_B_COLS: cols_cfg = pwdata[mme_pkg::CFG_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        case (in_data.command)
          mme_pkg::CMD_LOAD_A:
            a_store[int'(in_data.row_index)*DIM + int'(in_data.col_index)] =
              in_data.element_value;
          mme_pkg::CMD_LOAD_B:
            b_store[int'(in_data.row_index)*DIM + int'(in_data.col_index)] =
              in_data.element_value;
          mme_pkg::CMD_START: queue_product_matrix();
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (product_elements.size() == 0) begin
          $error("unexpected result: row %0d col %0d value %h", out_data.out_row,
                 out_data.out_col, out_data.out_value);
          errors++;
        end else begin
          want = product_elements.pop_front();
          if (out_data.out_row !== want.out_row) begin
            $error("out_row expected %0d got %0d", want.out_row, out_data.out_row);
            errors++;
          end
          if (out_data.out_col !== want.out_col) begin
            $error("out_col expected %0d got %0d", want.out_col, out_data.out_col);
            errors++;
          end
          if (out_data.out_value !== want.out_value) begin
            $error("out_value expected %h got %h", want.out_value, out_data.out_value);
            errors++;
          end
          if (out_data.last_element !== want.last_element) begin
            $error("last_element expected %0b got %0b", want.last_element,
                   out_data.last_element);
            errors++;
          end
        end
      end
    end
    mismatch_count <= errors;
    outstanding    <= product_elements.size();
  end

endmodule

// File: tb/tb_matrix_multiply_engine.sv
// Testbench top for the matrix multiply engine: clock, reset, request and config stimulus,
// random output stalls and the final verdict.
// Depends on mme_pkg, matrix_multiply_engine and mme_checker.
module tb_matrix_multiply_engine;

  localparam int         DIM        = mme_pkg::MAX_DIM_DEF;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int         SETTLE     = 24;
  localparam int         LONG_HOLD  = 400;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  mme_pkg::in_req_t              in_data;
  logic                          out_valid;
  logic                          out_stall;
  mme_pkg::out_res_t             out_data;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [mme_pkg::PADDR_W-1:0]   paddr;
  logic [mme_pkg::PDATA_W-1:0]   pwdata;
  logic [mme_pkg::PDATA_W-1:0]   prdata;
  logic                          pready;
  int                            mismatches;
  int                            outstanding;

  bit                            quiet = 1'b0;
  bit                            hold_req = 1'b0;
  int                            request_count = 0;
  bit                            a_loaded [DIM*DIM];
  bit                            b_loaded [DIM*DIM];
  logic [mme_pkg::CFG_W-1:0]     rows_set = mme_pkg::DIM_RESET;
  logic [mme_pkg::CFG_W-1:0]     inner_set = mme_pkg::DIM_RESET;
  logic [mme_pkg::CFG_W-1:0]     cols_set = mme_pkg::DIM_RESET;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  matrix_multiply_engine uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  mme_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .mismatch_count (mismatches),
    .outstanding    (outstanding)
  );

  function automatic int dim_of(logic [mme_pkg::CFG_W-1:0] v);
    if (v == '0) begin
      return 1;
    end
    return (int'(v) > DIM) ? DIM : int'(v);
  endfunction

  function automatic logic [mme_pkg::CFG_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return mme_pkg::CFG_W'(0);
      1: return mme_pkg::CFG_W'(15);
      2: return mme_pkg::CFG_W'(8);
      3: return mme_pkg::CFG_W'($urandom_range(9, 14));
      default: return mme_pkg::CFG_W'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic [mme_pkg::DATA_W-1:0] pick_value();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'h0001_0000;
      4: return 32'hFFFF_0000;
      5, 6: return {{14{r[17]}}, r[17:0]};
      default: return r;
    endcase
  endfunction

  // one request, held until accepted; in_valid stays high on return
  task automatic send_request(logic [1:0] cmd, int row, int col,
                              logic [mme_pkg::DATA_W-1:0] val);
    mme_pkg::in_req_t req;
    if (!quiet && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req.command       = cmd;
    req.row_index     = mme_pkg::POS_W'(row);
    req.col_index     = mme_pkg::POS_W'(col);
    req.element_value = val;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    if (cmd == mme_pkg::CMD_LOAD_A) begin
      a_loaded[row*DIM+col] = 1'b1;
    end else if (cmd == mme_pkg::CMD_LOAD_B) begin
      b_loaded[row*DIM+col] = 1'b1;
    end
    if (cmd != CMD_UNUSED) begin
      request_count++;
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] sel, logic [mme_pkg::CFG_W-1:0] val);
    in_valid <= 1'b0;
    psel     <= 1'b1;
    penable  <= 1'b0;
    pwrite   <= 1'b1;
    paddr    <= {sel, 2'b00};
    pwdata   <= mme_pkg::PDATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (sel)
      mme_pkg::REG_A_ROWS: rows_set = val;
      mme_pkg::REG_INNER:  inner_set = val;
      default:             cols_set = val;
    endcase
    @(posedge clk);
  endtask

  task automatic set_dims(logic [mme_pkg::CFG_W-1:0] r, logic [mme_pkg::CFG_W-1:0] k,
                          logic [mme_pkg::CFG_W-1:0] c);
    wait_drained();
    cfg_write(mme_pkg::REG_A_ROWS, r);
    cfg_write(mme_pkg::REG_INNER, k);
    cfg_write(mme_pkg::REG_B_COLS, c);
  endtask

  // loads every element the next product needs, some reloads and noise, then one or two starts
  task automatic run_job();
    int m;
    int n;
    int p;
    m = dim_of(rows_set);
    n = dim_of(inner_set);
    p = dim_of(cols_set);
    for (int i = 0; i < m; i++) begin
      for (int k = 0; k < n; k++) begin
        if (!a_loaded[i*DIM+k] || $urandom_range(0, 3) == 0) begin
          send_request(mme_pkg::CMD_LOAD_A, i, k, pick_value());
        end
      end
    end
    for (int k = 0; k < n; k++) begin
      for (int j = 0; j < p; j++) begin
        if (!b_loaded[k*DIM+j] || $urandom_range(0, 3) == 0) begin
          send_request(mme_pkg::CMD_LOAD_B, k, j, pick_value());
        end
      end
    end
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 2))
        0: send_request(mme_pkg::CMD_LOAD_A, $urandom_range(0, 7), $urandom_range(0, 7),
                        pick_value());
        1: send_request(mme_pkg::CMD_LOAD_B, $urandom_range(0, 7), $urandom_range(0, 7),
                        pick_value());
        default: send_request(CMD_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7),
                              $urandom);
      endcase
    end
    send_request(mme_pkg::CMD_START, $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
    if ($urandom_range(0, 4) == 0) begin
      send_request(mme_pkg::CMD_START, $urandom_range(0, 7), $urandom_range(0, 7),
                   $urandom);
    end
  endtask

  // output side: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 7);
      end
    end
  end

  initial begin
    #24_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int job;
    int random_base;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // single-element products; zero size registers act as one
    set_dims(mme_pkg::CFG_W'(0), mme_pkg::CFG_W'(1), mme_pkg::CFG_W'(0));
    send_request(mme_pkg::CMD_LOAD_A, 0, 0, 32'h7FFF_FFFF);
    send_request(mme_pkg::CMD_LOAD_B, 0, 0, 32'h7FFF_FFFF);
    send_request(mme_pkg::CMD_START, 0, 0, 32'h0);
    send_request(mme_pkg::CMD_LOAD_B, 0, 0, 32'h8000_0000);
    send_request(mme_pkg::CMD_START, 7, 7, 32'hFFFF_FFFF);
    send_request(mme_pkg::CMD_LOAD_A, 0, 0, 32'h8000_0000);
    send_request(mme_pkg::CMD_START, 0, 0, 32'h0);
    // rounding at exactly half, both signs, and just below negative half
    send_request(mme_pkg::CMD_LOAD_A, 0, 0, 32'h0000_0001);
    send_request(mme_pkg::CMD_LOAD_B, 0, 0, 32'h0000_8000);
    send_request(mme_pkg::CMD_START, 0, 0, 32'h0);
    send_request(mme_pkg::CMD_LOAD_B, 0, 0, 32'hFFFF_8000);
    send_request(mme_pkg::CMD_START, 0, 0, 32'h0);
    send_request(mme_pkg::CMD_LOAD_B, 0, 0, 32'hFFFF_7FFF);
    send_request(mme_pkg::CMD_START, 0, 0, 32'h0);
    // unused command must leave the stores alone
    send_request(CMD_UNUSED, 0, 0, 32'hFFFF_FFFF);
    send_request(mme_pkg::CMD_START, 0, 0, 32'h0);
    send_request(mme_pkg::CMD_LOAD_A, 7, 7, 32'hFFFF_FFFF);
    send_request(mme_pkg::CMD_LOAD_B, 7, 7, 32'h0000_0000);

    random_base = request_count;
    job = 0;
    while (request_count - random_base < 500) begin
      if (job == 5) begin
        set_dims(mme_pkg::CFG_W'(15), mme_pkg::CFG_W'(15), mme_pkg::CFG_W'(15));
      end else if (job != 6 && job != 7 && $urandom_range(0, 3) == 0) begin
        set_dims(pick_dim(), pick_dim(), pick_dim());
      end else if (job != 7 && $urandom_range(0, 5) == 0) begin
        wait_drained();
      end
      if (job == 6) begin
        hold_req <= 1'b1;
      end
      quiet <= (job >= 10 && job < 15);
      run_job();
      job++;
    end

    wait_drained();
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/mme_pkg.sv
rtl/mme_store.sv
rtl/mme_seq.sv
rtl/mme_mac.sv
rtl/matrix_multiply_engine.sv
tb/mme_checker.sv
tb/tb_matrix_multiply_engine.sv
